[src/framed_packet_receiver_xor_check_core_defines.svh]
// Assertion macros for the framed packet receiver core.
// Included by the top level only; no other dependencies.
`ifndef FRAMED_PACKET_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH

// Implication checked on every rising edge, quiet during reset.
`define FPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fpr_pkg.sv]
// Shared types and constants for the framed packet receiver.
// No dependencies.
`timescale 1ns / 1ps

package fpr_pkg;

    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_FOOTER = 2'd1;
    localparam logic [1:0] REG_MAXLEN = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_CSUM   = 2'd1;
    localparam logic [1:0] STATUS_FOOTER = 2'd2;

    localparam logic [15:0] MAXLEN_RESET = 16'd1008;

    // Receiver modes, one-hot
    typedef enum logic [8:0] {
        MODE_HUNT = 9'b000000001,
        MODE_TGT  = 9'b000000010,
        MODE_SRC  = 9'b000000100,
        MODE_PRM  = 9'b000001000,
        MODE_CMD  = 9'b000010000,
        MODE_LEN  = 9'b000100000,
        MODE_DATA = 9'b001000000,
        MODE_CSUM = 9'b010000000,
        MODE_FOOT = 9'b100000000
    } mode_t;

    // One result request passed from the front to the back
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [1:0]  status;
        logic [15:0] target_id;
        logic [15:0] source_id;
        logic [15:0] param_word;
        logic [15:0] command_word;
        logic [15:0] payload_length;
    } rec_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] footer_word;
        logic [15:0] max_payload_len;
    } cfg_t;

endpackage

[src/fpr_front.sv]
// Front end: frame parser, one byte per cycle while in_valid is high, emits result requests.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_front
    import fpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    output logic       rec_valid,
    output rec_t       rec
);

    mode_t       mode_reg, mode_next;
    logic        phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] xor_reg, xor_next;
    logic [15:0] tgt_reg, tgt_next, src_reg, src_next, prm_reg, prm_next;
    logic [15:0] cmd_reg, cmd_next, len_reg, len_next;
    logic [15:0] csum_reg, csum_next;
    logic [15:0] word;

    assign word = {rx_byte, hold_reg};

    // Parser next state and result request
    always_comb
    begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        xor_next    = xor_reg;
        tgt_next    = tgt_reg;
        src_next    = src_reg;
        prm_next    = prm_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        csum_next   = csum_reg;
        rec_valid   = 1'b0;
        rec.kind           = 1'b0;
        rec.payload_byte   = 8'd0;
        rec.payload_index  = 16'd0;
        rec.status         = STATUS_OK;
        rec.target_id      = tgt_reg;
        rec.source_id      = src_reg;
        rec.param_word     = prm_reg;
        rec.command_word   = cmd_reg;
        rec.payload_length = len_reg;
        if (in_valid)
        begin
            if (mode_reg != MODE_HUNT && mode_reg != MODE_DATA)
            begin
                phase_next = ~phase_reg;
                if (!phase_reg)
                    hold_next = rx_byte;
            end
            case (mode_reg)
                MODE_HUNT:
                begin
                    if (!phase_reg)
                    begin
                        if (rx_byte == cfg.header_word[7:0])
                        begin
                            hold_next  = rx_byte;
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (rx_byte == cfg.header_word[15:8])
                        begin
                            xor_next  = cfg.header_word;
                            mode_next = MODE_TGT;
                        end
                    end
                end
                MODE_TGT, MODE_SRC, MODE_PRM, MODE_CMD:
                begin
                    if (phase_reg)
                    begin
                        xor_next = xor_reg ^ word;
                        case (mode_reg)
                            MODE_TGT: begin tgt_next = word; mode_next = MODE_SRC; end
                            MODE_SRC: begin src_next = word; mode_next = MODE_PRM; end
                            MODE_PRM: begin prm_next = word; mode_next = MODE_CMD; end
                            default:  begin cmd_next = word; mode_next = MODE_LEN; end
                        endcase
                    end
                end
                MODE_LEN:
                begin
                    if (phase_reg)
                    begin
                        len_next = word;
                        xor_next = xor_reg ^ word;
                        if (word == 16'd0)
                            mode_next = MODE_CSUM;
                        else if (word <= cfg.max_payload_len)
                        begin
                            mode_next   = MODE_DATA;
                            remain_next = word;
                            pos_next    = 16'd0;
                        end
                        else
                            mode_next = MODE_HUNT;
                    end
                end
                MODE_DATA:
                begin
                    rec_valid         = 1'b1;
                    rec.payload_byte  = rx_byte;
                    rec.payload_index = pos_reg;
                    phase_next = ~phase_reg;
                    if (!phase_reg)
                        hold_next = rx_byte;
                    else
                        xor_next = xor_reg ^ word;
                    pos_next    = pos_reg + 16'd1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1)
                    begin
                        mode_next  = MODE_CSUM;
                        phase_next = 1'b0;
                    end
                end
                MODE_CSUM:
                begin
                    if (phase_reg)
                    begin
                        csum_next = word;
                        mode_next = MODE_FOOT;
                    end
                end
                MODE_FOOT:
                begin
                    if (phase_reg)
                    begin
                        mode_next = MODE_HUNT;
                        rec_valid = 1'b1;
                        rec.kind  = 1'b1;
                        if (csum_reg != ~xor_reg)
                            rec.status = STATUS_CSUM;
                        else if (word != cfg.footer_word)
                            rec.status = STATUS_FOOTER;
                        else
                            rec.status = STATUS_OK;
                    end
                end
                default:
                begin
                    mode_next  = MODE_HUNT;
                    phase_next = 1'b0;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            phase_reg  <= 1'b0;
            remain_reg <= 16'd0;
            pos_reg    <= 16'd0;
            hold_reg   <= 8'd0;
            xor_reg    <= 16'd0;
            tgt_reg    <= 16'd0;
            src_reg    <= 16'd0;
            prm_reg    <= 16'd0;
            cmd_reg    <= 16'd0;
            len_reg    <= 16'd0;
            csum_reg   <= 16'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            hold_reg   <= hold_next;
            xor_reg    <= xor_next;
            tgt_reg    <= tgt_next;
            src_reg    <= src_next;
            prm_reg    <= prm_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            csum_reg   <= csum_next;
        end
    end

endmodule

[src/fpr_queue.sv]
// Short request queue between parser and result port; registered storage.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_queue
    import fpr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  rec_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output rec_t rd_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t            mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];
    assign level   = cnt_reg;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(do_wr) - CW'(do_rd);
        end
    end

endmodule

[src/framed_packet_receiver_xor_check_core.sv]
// Top level of the framed packet receiver: APB register file, parser, result queue.
// Depends on fpr_pkg, fpr_front, fpr_queue and the defines header.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  input    | push / full      | rx_byte
//  result   | pop / empty      | kind, payload_byte, payload_index, status, fields
//  config   | APB psel/penable | paddr, pwdata, prdata
//
// One byte is taken per cycle while full is low.
// A request is registered in the queue storage before it reaches the result port.
// full rises when the queue cannot absorb another request (DEPTH entries).
// Reset clears the parser and the queue at once; no clearing pass.
`timescale 1ns / 1ps
`include "framed_packet_receiver_xor_check_core_defines.svh"

module framed_packet_receiver_xor_check_core
    import fpr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [1:0]  status,
    output logic [15:0] target_id,
    output logic [15:0] source_id,
    output logic [15:0] param_word,
    output logic [15:0] command_word,
    output logic [15:0] payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = $clog2(DEPTH + 1);

    cfg_t cfg_reg;
    logic cfg_wr;
    logic [1:0] reg_idx;
    logic in_valid, rec_valid, q_full;
    rec_t rec, q_out;
    logic [LW-1:0] q_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word     <= 16'd0;
            cfg_reg.footer_word     <= 16'd0;
            cfg_reg.max_payload_len <= MAXLEN_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_HEADER: cfg_reg.header_word     <= pwdata[15:0];
                REG_FOOTER: cfg_reg.footer_word     <= pwdata[15:0];
                REG_MAXLEN: cfg_reg.max_payload_len <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_HEADER: prdata = {16'd0, cfg_reg.header_word};
            REG_FOOTER: prdata = {16'd0, cfg_reg.footer_word};
            REG_MAXLEN: prdata = {16'd0, cfg_reg.max_payload_len};
            default:    prdata = 32'd0;
        endcase
    end

    // A payload or footer byte may cause a request, so hold off while the queue is full
    assign full     = q_full;
    assign in_valid = push && !q_full;

    fpr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .rx_byte   (rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    fpr_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .full    (q_full),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (q_out),
        .level   (q_level)
    );

    assign kind           = q_out.kind;
    assign payload_byte   = q_out.payload_byte;
    assign payload_index  = q_out.payload_index;
    assign status         = q_out.status;
    assign target_id      = q_out.target_id;
    assign source_id      = q_out.source_id;
    assign param_word     = q_out.param_word;
    assign command_word   = q_out.command_word;
    assign payload_length = q_out.payload_length;

    `FPR_ASSERT_IMP(a_full_level, clk, rst_n, full, q_level == LW'(DEPTH), "full without a full queue")
    `FPR_ASSERT_NEXT(a_req_lands, clk, rst_n, rec_valid && !pop, !empty, "request lost on its way to the queue")
    `FPR_ASSERT_IMP(a_no_req_idle, clk, rst_n, !in_valid, !rec_valid, "request raised without an accepted byte")

endmodule

[tb/sv/fpr_checker.sv]
// Checker for the framed packet receiver: predicts records from accepted bytes
// and compares them with popped records. Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_checker
    import fpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        kind,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] payload_index,
    input  logic [1:0]  status,
    input  logic [15:0] target_id,
    input  logic [15:0] source_id,
    input  logic [15:0] param_word,
    input  logic [15:0] command_word,
    input  logic [15:0] payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          frames_seen,
    output int          bytes_seen
);

    // Mirror of the receiver configuration and parser state
    logic [15:0] hdr_cfg, ftr_cfg, maxlen_cfg;
    mode_t       rx_state;
    logic        hi_phase;
    logic [15:0] left_cnt, pos_cnt, xor_acc, csum_rx;
    logic [7:0]  lo_hold;
    logic [15:0] words [5];
    rec_t        expected_q [$];

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Advance the predicted parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] w;
        logic        done;
        rec_t        r;
        w = {b, lo_hold};
        done = hi_phase;
        r = '0;
        r.target_id = words[0];
        r.source_id = words[1];
        r.param_word = words[2];
        r.command_word = words[3];
        r.payload_length = words[4];
        if (!hi_phase)
            lo_hold = b;
        hi_phase = !hi_phase;
        case (rx_state)
            MODE_HUNT:
            begin
                if (!done) begin
                    if (b != hdr_cfg[7:0])
                        hi_phase = 1'b0;
                end else if (b == hdr_cfg[15:8]) begin
                    xor_acc = hdr_cfg;
                    rx_state = MODE_TGT;
                end
            end
            MODE_TGT, MODE_SRC, MODE_PRM, MODE_CMD:
            begin
                if (done) begin
                    xor_acc ^= w;
                    case (rx_state)
                        MODE_TGT: begin words[0] = w; rx_state = MODE_SRC; end
                        MODE_SRC: begin words[1] = w; rx_state = MODE_PRM; end
                        MODE_PRM: begin words[2] = w; rx_state = MODE_CMD; end
                        default:  begin words[3] = w; rx_state = MODE_LEN; end
                    endcase
                end
            end
            MODE_LEN:
            begin
                if (done) begin
                    words[4] = w;
                    xor_acc ^= w;
                    if (w == 16'd0)
                        rx_state = MODE_CSUM;
                    else if (w <= maxlen_cfg) begin
                        rx_state = MODE_DATA;
                        left_cnt = w;
                        pos_cnt = 16'd0;
                    end else
                        rx_state = MODE_HUNT;
                end
            end
            MODE_DATA:
            begin
                r.kind = 1'b0;
                r.payload_byte = b;
                r.payload_index = pos_cnt;
                expected_q.push_back(r);
                if (done)
                    xor_acc ^= w;
                pos_cnt++;
                left_cnt--;
                if (left_cnt == 16'd0) begin
                    rx_state = MODE_CSUM;
                    hi_phase = 1'b0;
                end
            end
            MODE_CSUM:
            begin
                if (done) begin
                    csum_rx = w;
                    rx_state = MODE_FOOT;
                end
            end
            default:
            begin
                if (done) begin
                    rx_state = MODE_HUNT;
                    r.kind = 1'b1;
                    if (csum_rx != ~xor_acc)
                        r.status = STATUS_CSUM;
                    else if (w != ftr_cfg)
                        r.status = STATUS_FOOTER;
                    else
                        r.status = STATUS_OK;
                    expected_q.push_back(r);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_cfg = 16'd0;
            ftr_cfg = 16'd0;
            maxlen_cfg = MAXLEN_RESET;
            rx_state = MODE_HUNT;
            hi_phase = 1'b0;
            left_cnt = 16'd0;
            pos_cnt = 16'd0;
            xor_acc = 16'd0;
            csum_rx = 16'd0;
            lo_hold = 8'd0;
            foreach (words[i]) words[i] = 16'd0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            frames_seen = 0;
            bytes_seen = 0;
        end else begin
            // Register writes
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_HEADER: hdr_cfg = pwdata[15:0];
                    REG_FOOTER: ftr_cfg = pwdata[15:0];
                    REG_MAXLEN: maxlen_cfg = pwdata[15:0];
                    default: ;
                endcase
            end
            // Compare a popped request with the oldest prediction
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected record at %0t", $time);
                    fail_count++;
                end else begin
                    rec_t e;
                    e = expected_q.pop_front();
                    if (kind != e.kind) report("kind", 16'(kind), 16'(e.kind));
                    if (payload_byte != e.payload_byte)
                        report("payload_byte", 16'(payload_byte), 16'(e.payload_byte));
                    if (payload_index != e.payload_index)
                        report("payload_index", payload_index, e.payload_index);
                    if (status != e.status) report("status", 16'(status), 16'(e.status));
                    if (target_id != e.target_id) report("target_id", target_id, e.target_id);
                    if (source_id != e.source_id) report("source_id", source_id, e.source_id);
                    if (param_word != e.param_word) report("param_word", param_word, e.param_word);
                    if (command_word != e.command_word)
                        report("command_word", command_word, e.command_word);
                    if (payload_length != e.payload_length)
                        report("payload_length", payload_length, e.payload_length);
                    if (e.kind) frames_seen++; else bytes_seen++;
                end
            end
            if (push && !full)
                parse_byte(rx_byte);
            pending = expected_q.size();
        end
    end

endmodule

[tb/sv/framed_packet_receiver_xor_check_core_test.sv]
// Testbench top for the framed packet receiver: clock, reset, byte stimulus,
// register writes and verdict. Depends on fpr_pkg, the core and fpr_checker.
`timescale 1ns / 1ps

module framed_packet_receiver_xor_check_core_test;
    import fpr_pkg::*;

    logic        clk, rst_n, push, full, empty, pop;
    logic [7:0]  rx_byte, payload_byte;
    logic        kind;
    logic [15:0] payload_index, target_id, source_id, param_word, command_word, payload_length;
    logic [1:0]  status;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, frames_seen, bytes_seen;
    int          cycle_count;
    bit          quiet_send, quiet_recv, hold_recv;
    logic [15:0] hdr_cur, ftr_cur, max_cur;

    framed_packet_receiver_xor_check_core uut (.*);
    fpr_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("framed_packet_receiver_xor_check_core_test NOT OK");
            $finish;
        end
    end

    // Receiver side: random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (hold_recv)
            pop <= 1'b0;
        else if (quiet_recv)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= 9);
    end

    // push stays high after a byte so that bytes can follow back to back
    task automatic send_byte(input logic [7:0] b);
        while (!quiet_send && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    // One frame; err selects a broken checksum (1) or footer (2)
    task automatic send_frame(input int len, input int err);
        logic [15:0] acc, w, f;
        acc = hdr_cur;
        send_word(hdr_cur);
        for (int i = 0; i < 4; i++) begin
            w = 16'($urandom);
            acc ^= w;
            send_word(w);
        end
        acc ^= len[15:0];
        send_word(len[15:0]);
        if (len <= max_cur) begin
            for (int i = 0; i < len; i++) begin
                w[7:0] = 8'($urandom);
                if (i % 2 == 0) f[7:0] = w[7:0];
                else acc ^= {w[7:0], f[7:0]};
                send_byte(w[7:0]);
            end
            send_word(err == 1 ? acc : ~acc);
            send_word(err == 2 ? ~ftr_cur : ftr_cur);
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] h, input logic [15:0] f, input logic [15:0] m);
        settle();
        hdr_cur = h; ftr_cur = f; max_cur = m;
        reg_write(REG_HEADER, h);
        reg_write(REG_FOOTER, f);
        reg_write(REG_MAXLEN, m);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0; pop = 1'b0; rx_byte = 8'd0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 4'd0; pwdata = 32'd0;
        quiet_send = 1'b0; quiet_recv = 1'b0; hold_recv = 1'b0;
        cycle_count = 0;
        hdr_cur = 16'd0; ftr_cur = 16'd0; max_cur = MAXLEN_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then extremes and special cases
        send_frame(2, 0);
        configure(16'h55AA, 16'h0DF0, 16'd6);
        send_byte(8'hAA); send_byte(8'h12);          // wrong second header byte
        send_byte(8'hAA); send_byte(8'hAA); send_byte(8'h55);
        send_byte(8'h00); send_byte(8'hFF);
        settle();
        configure(16'h55AA, 16'h0DF0, 16'd6);
        send_frame(0, 0);
        send_frame(7, 0);                             // above limit, dropped
        send_frame(6, 0);
        send_frame(5, 0);                             // odd length
        send_frame(3, 1);
        send_frame(4, 2);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(1, 0);
        send_frame(2, 1);
        configure(16'h0000, 16'h0000, 16'd0);
        send_frame(0, 2);
        send_frame(1, 0);                             // above zero limit

        // Long receiver hold-off while bytes keep coming
        configure(16'h3C5A, 16'h1234, 16'd64);
        fork
            begin
                hold_recv = 1'b1;
                repeat (150) @(posedge clk);
                hold_recv = 1'b0;
            end
            send_frame(20, 0);
        join

        // Random frames with random content, some noise between them
        for (int n = 0; n < 10; n++) begin
            if (n % 5 == 0)
                configure(16'($urandom), 16'($urandom), 16'($urandom_range(12, 4)));
            quiet_send = (n >= 4 && n < 8);
            quiet_recv = quiet_send;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
            send_frame($urandom_range(max_cur + 2), $urandom_range(3) % 3);
        end
        quiet_send = 1'b0; quiet_recv = 1'b0;
        send_frame(0, 0);
        settle();
        repeat (20) @(posedge clk);

        $display("Covered %0d frame end records and %0d payload byte records,",
                 frames_seen, bytes_seen);
        $display("with header, footer and length limit changed between phases.");
        if (fail_count == 0)
            $display("framed_packet_receiver_xor_check_core_test OK");
        else
            $display("framed_packet_receiver_xor_check_core_test NOT OK");
        $finish;
    end

endmodule
